### sv/sfr_pkg.sv
// Shared types, codes and the CRC-16/ARC byte update for the stuffed frame receiver.
package sfr_pkg;

    localparam int CfgIndexWidth = 3;
    localparam int CfgDataWidth  = 16;

    // Configuration register indexes
    localparam logic [CfgIndexWidth-1:0] CFG_LOCAL_ADDRESS    = 3'd0;
    localparam logic [CfgIndexWidth-1:0] CFG_PAYLOAD_CAPACITY = 3'd1;
    localparam logic [CfgIndexWidth-1:0] CFG_FLAG_VALUE       = 3'd2;
    localparam logic [CfgIndexWidth-1:0] CFG_ESCAPE_VALUE     = 3'd3;
    localparam logic [CfgIndexWidth-1:0] CFG_XOR_MASK         = 3'd4;

    // Configuration reset values
    localparam logic [7:0]  RST_LOCAL_ADDRESS    = 8'd0;
    localparam logic [15:0] RST_PAYLOAD_CAPACITY = 16'd1024;
    localparam logic [7:0]  RST_FLAG_VALUE       = 8'd126;
    localparam logic [7:0]  RST_ESCAPE_VALUE     = 8'd125;
    localparam logic [7:0]  RST_XOR_MASK         = 8'd32;

    // Result status codes
    localparam logic [1:0] ST_BUSY  = 2'd0;
    localparam logic [1:0] ST_ERROR = 2'd1;
    localparam logic [1:0] ST_READY = 2'd2;

    localparam logic [15:0] CRC_POLY_REFLECTED = 16'hA001;

    typedef enum logic [2:0] {
        PH_WAIT    = 3'd0,
        PH_SRC     = 3'd1,
        PH_DST     = 3'd2,
        PH_LEN_LO  = 3'd3,
        PH_LEN_HI  = 3'd4,
        PH_PAYLOAD = 3'd5,
        PH_CRC_LO  = 3'd6,
        PH_CRC_HI  = 3'd7
    } phase_t;

    typedef struct packed {
        logic [7:0]  local_address;
        logic [15:0] payload_capacity;
        logic [7:0]  flag_value;
        logic [7:0]  escape_value;
        logic [7:0]  xor_mask;
    } cfg_t;

    typedef struct packed {
        logic [1:0]  status;
        logic        payload_valid;
        logic [7:0]  payload_byte;
        logic [15:0] payload_index;
        logic [7:0]  source_address;
        logic [15:0] frame_len;
    } result_t;

    // One byte of reflected CRC-16/ARC, unrolled over the eight bits
    function automatic logic [15:0] crc_arc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'd0, b};
        for (int k = 0; k < 8; k++) begin
            if (c[0])
                c = (c >> 1) ^ CRC_POLY_REFLECTED;
            else
                c = c >> 1;
        end
        return c;
    endfunction

endpackage

### sv/sfr_cfg.sv
// Configuration register bank of the stuffed frame receiver.
module sfr_cfg
    import sfr_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_we,
    input  logic [CfgIndexWidth-1:0] cfg_index,
    input  logic [CfgDataWidth-1:0]  cfg_data,
    output cfg_t                     cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                CFG_LOCAL_ADDRESS:    cfg_next.local_address    = cfg_data[7:0];
                CFG_PAYLOAD_CAPACITY: cfg_next.payload_capacity = cfg_data;
                CFG_FLAG_VALUE:       cfg_next.flag_value       = cfg_data[7:0];
                CFG_ESCAPE_VALUE:     cfg_next.escape_value     = cfg_data[7:0];
                CFG_XOR_MASK:         cfg_next.xor_mask         = cfg_data[7:0];
                default:              cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.local_address    <= RST_LOCAL_ADDRESS;
            cfg_reg.payload_capacity <= RST_PAYLOAD_CAPACITY;
            cfg_reg.flag_value       <= RST_FLAG_VALUE;
            cfg_reg.escape_value     <= RST_ESCAPE_VALUE;
            cfg_reg.xor_mask         <= RST_XOR_MASK;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

### sv/sfr_deframer.sv
// Unstuffing, frame parsing and CRC check: one wire word per step.
module sfr_deframer
    import sfr_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       step_en,
    input  logic [7:0] raw_byte,
    input  cfg_t       cfg,
    output result_t    result
);

    phase_t      phase_reg,  phase_next;
    logic        esc_reg,    esc_next;
    logic [7:0]  src_reg,    src_next;
    logic [15:0] len_reg,    len_next;
    logic [15:0] cnt_reg,    cnt_next;
    logic [15:0] crc_reg,    crc_next;
    logic [7:0]  rcrc_lo_reg, rcrc_lo_next;

    logic        is_flag;
    logic        have;
    logic [7:0]  d;
    logic [15:0] len_full;
    logic [15:0] cnt_inc;

    // Decode the wire byte: flag, escape, or data
    always_comb
    begin
        is_flag = !esc_reg && (raw_byte == cfg.flag_value);
        have    = 1'b0;
        d       = raw_byte;
        if (!is_flag && (phase_reg != PH_WAIT))
        begin
            if (esc_reg)
            begin
                have = 1'b1;
                d    = raw_byte ^ cfg.xor_mask;
            end
            else if (raw_byte != cfg.escape_value)
            begin
                have = 1'b1;
            end
        end
    end

    assign len_full = {d, len_reg[7:0]};
    assign cnt_inc  = cnt_reg + 16'd1;

    // Next state
    always_comb
    begin
        phase_next   = phase_reg;
        esc_next     = esc_reg;
        src_next     = src_reg;
        len_next     = len_reg;
        cnt_next     = cnt_reg;
        crc_next     = crc_reg;
        rcrc_lo_next = rcrc_lo_reg;
        if (is_flag)
        begin
            phase_next = PH_SRC;
        end
        else if (phase_reg != PH_WAIT)
        begin
            if (esc_reg)
                esc_next = 1'b0;
            else if (raw_byte == cfg.escape_value)
                esc_next = 1'b1;
            if (have)
            begin
                case (phase_reg)
                    PH_SRC:
                    begin
                        src_next   = d;
                        phase_next = PH_DST;
                    end
                    PH_DST:
                    begin
                        phase_next = (d != cfg.local_address) ? PH_WAIT : PH_LEN_LO;
                    end
                    PH_LEN_LO:
                    begin
                        len_next   = {8'd0, d};
                        phase_next = PH_LEN_HI;
                    end
                    PH_LEN_HI:
                    begin
                        len_next = len_full;
                        cnt_next = 16'd0;
                        crc_next = 16'd0;
                        if (len_full > cfg.payload_capacity)
                            phase_next = PH_WAIT;
                        else if (len_full == 16'd0)
                            phase_next = PH_CRC_LO;
                        else
                            phase_next = PH_PAYLOAD;
                    end
                    PH_PAYLOAD:
                    begin
                        cnt_next = cnt_inc;
                        crc_next = crc_arc_byte(crc_reg, d);
                        if (cnt_inc == len_reg)
                            phase_next = PH_CRC_LO;
                    end
                    PH_CRC_LO:
                    begin
                        rcrc_lo_next = d;
                        phase_next   = PH_CRC_HI;
                    end
                    PH_CRC_HI:
                    begin
                        phase_next = PH_WAIT;
                    end
                    default:
                    begin
                        phase_next = PH_WAIT;
                    end
                endcase
            end
        end
    end

    // Result of this step
    always_comb
    begin
        result = '0;
        result.status = ST_BUSY;
        if (have)
        begin
            case (phase_reg)
                PH_DST:
                begin
                    if (d != cfg.local_address)
                        result.status = ST_ERROR;
                end
                PH_LEN_HI:
                begin
                    if (len_full > cfg.payload_capacity)
                        result.status = ST_ERROR;
                end
                PH_PAYLOAD:
                begin
                    result.payload_valid = 1'b1;
                    result.payload_byte  = d;
                    result.payload_index = cnt_reg;
                end
                PH_CRC_HI:
                begin
                    if ({d, rcrc_lo_reg} != crc_reg)
                    begin
                        result.status = ST_ERROR;
                    end
                    else
                    begin
                        result.status         = ST_READY;
                        result.source_address = src_reg;
                        result.frame_len      = len_reg;
                    end
                end
                default:
                begin
                    result.status = ST_BUSY;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_WAIT;
            esc_reg     <= 1'b0;
            src_reg     <= 8'd0;
            len_reg     <= 16'd0;
            cnt_reg     <= 16'd0;
            crc_reg     <= 16'd0;
            rcrc_lo_reg <= 8'd0;
        end
        else if (step_en)
        begin
            phase_reg   <= phase_next;
            esc_reg     <= esc_next;
            src_reg     <= src_next;
            len_reg     <= len_next;
            cnt_reg     <= cnt_next;
            crc_reg     <= crc_next;
            rcrc_lo_reg <= rcrc_lo_next;
        end
    end

endmodule

### sv/stuffed_frame_receiver_crc16.sv
// Path: an accepted word waits in the input register, and its result is then loaded into the result register.
// Throughput: one word per cycle; the CRC byte update and the phase step fit between the
//   input register and the result register, so the block takes a word every cycle unless a held result stalls it.
// A held result stalls the input side only when both registers are full.
// Reset (rst_n low, asynchronous) empties both registers, returns the parser to waiting for a
//   flag and loads the configuration defaults (flag 126, escape 125, mask 32, capacity 1024).
module stuffed_frame_receiver_crc16
    import sfr_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    // Wire byte input
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [7:0]               raw_byte,
    // Result output
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic [1:0]               status,
    output logic                     payload_valid,
    output logic [7:0]               payload_byte,
    output logic [15:0]              payload_index,
    output logic [7:0]               source_address,
    output logic [15:0]              frame_len,
    // Configuration writes
    input  logic                     cfg_we,
    input  logic [CfgIndexWidth-1:0] cfg_index,
    input  logic [CfgDataWidth-1:0]  cfg_data
);

    cfg_t       cfg;
    result_t    step_result;

    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       out_valid_reg;
    result_t    out_reg;

    logic       step_en;

    // Advance the input word into the result register whenever that slot is free or draining.
    assign step_en  = in_valid_reg && (!out_valid_reg || out_ready);
    // Take a new word when the input register is empty or moves on this cycle.
    assign in_ready = !in_valid_reg || step_en;

    sfr_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    sfr_deframer u_deframer (
        .clk      (clk),
        .rst_n    (rst_n),
        .step_en  (step_en),
        .raw_byte (in_byte_reg),
        .cfg      (cfg),
        .result   (step_result)
    );

    // Input register: hold the wire word until the parser consumes it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (in_ready)
            in_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            in_byte_reg <= raw_byte;
    end

    // Result register: hold the result until the consumer takes it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (step_en)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (step_en)
            out_reg <= step_result;
    end

    assign out_valid      = out_valid_reg;
    assign status         = out_reg.status;
    assign payload_valid  = out_reg.payload_valid;
    assign payload_byte   = out_reg.payload_byte;
    assign payload_index  = out_reg.payload_index;
    assign source_address = out_reg.source_address;
    assign frame_len      = out_reg.frame_len;

endmodule

### sv/sfr_checker.sv
// Port-level checks of the stuffed frame receiver, bound to the top level.
module sfr_checker
    import sfr_pkg::*;
(
    input logic                     clk,
    input logic                     rst_n,
    input logic                     out_valid,
    input logic                     out_ready,
    input logic [1:0]               status,
    input logic                     payload_valid,
    input logic [7:0]               payload_byte,
    input logic [15:0]              payload_index,
    input logic [7:0]               source_address,
    input logic [15:0]              frame_len
);

    // A stalled result holds its word.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status) && $stable(payload_byte)
            && $stable(payload_index) && $stable(frame_len))
        else $error("result changed while stalled");

    // A payload word never carries a frame verdict.
    a_payload_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && payload_valid |-> status == ST_BUSY && source_address == 8'd0
            && frame_len == 16'd0)
        else $error("payload word with frame status");

    // Non-payload words carry zero byte and index.
    a_no_payload_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !payload_valid |-> payload_byte == 8'd0 && payload_index == 16'd0)
        else $error("stale payload fields");

    // Source and length show only on frame ready.
    a_frame_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != ST_READY |-> source_address == 8'd0 && frame_len == 16'd0)
        else $error("frame fields outside frame ready");

    // Status never takes the unused code.
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> status == ST_BUSY || status == ST_ERROR || status == ST_READY)
        else $error("unused status code");

endmodule

bind stuffed_frame_receiver_crc16 sfr_checker u_sfr_checker (.*);
